>>> sv/assert_macros.svh
// Assertion macros shared by the binary to decimal ASCII converter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent assertion that a condition never holds at a rising clock edge.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> sv/b2da_pkg.sv
// Package with the state types and character codes of the decimal ASCII converter.
package b2da_pkg;

   // ASCII codes, trimmed to the 6-bit result field.
   localparam logic [5:0] CODE_MINUS = 6'd45;
   localparam logic [5:0] CODE_ZERO  = 6'd48;

   // Front end: take a request, run the binary to BCD steps, hand off to the queue.
   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CONVERT,
      FRONT_PUSH
   } front_state_type;

   // Back end: emit the sign, then the digits from the most significant one down.
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SIGN,
      BACK_DIGIT
   } back_state_type;

endpackage

>>> sv/b2da_front.sv
// Front end: accepts a request, takes its magnitude and converts it to BCD.
`include "assert_macros.svh"

module b2da_front #(
   parameter int VALUE_WIDTH = 64,
   parameter int NUM_DIGITS  = 19,
   parameter int DIGIT_W     = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [63:0]                       req_value,
   input  logic                              queue_full,
   output logic                              push,
   output logic [NUM_DIGITS*4+DIGIT_W:0]     push_entry
);

   // Four bits of the magnitude enter the BCD register per cycle.
   localparam int STEPS = (VALUE_WIDTH + 3) / 4;
   localparam int PAD_W = STEPS * 4;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   b2da_pkg::front_state_type state_ff, state_in;

   logic [PAD_W-1:0]                 bin_ff, bin_in;
   logic [NUM_DIGITS-1:0][3:0]       bcd_ff, bcd_in;
   logic                             neg_ff, neg_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;

   logic [VALUE_WIDTH-1:0]           x;
   logic [VALUE_WIDTH-1:0]           mag;
   logic [PAD_W-1:0]                 bin_step;
   logic [NUM_DIGITS-1:0][3:0]       bcd_step;
   logic [DIGIT_W-1:0]               top_idx;

   // Sign and magnitude; the most negative value comes out as an exact unsigned magnitude.
   always_comb begin
      x   = req_value[VALUE_WIDTH-1:0];
      mag = x[VALUE_WIDTH-1] ? (~x + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : x;
   end

   // Four shift-and-add-3 steps of the binary to BCD conversion.
   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int b = 0; b < 4; b++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_step[d] >= 4'd5) begin
               bcd_step[d] = bcd_step[d] + 4'd3;
            end
         end
         {bcd_step, bin_step} = {bcd_step, bin_step} << 1;
      end
   end

   // Position of the most significant nonzero digit; zero keeps position zero.
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d] != 4'd0) begin
            top_idx = DIGIT_W'(d);
         end
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // Next state and outputs.
   always_comb begin
      state_in   = state_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      busy       = 1'b1;
      push       = 1'b0;
      push_entry = {neg_ff, top_idx, bcd_ff};
      case (state_ff)
         b2da_pkg::FRONT_IDLE: begin
            busy = 1'b0;
            if (start) begin
               bin_in   = PAD_W'(mag);
               bcd_in   = '0;
               neg_in   = x[VALUE_WIDTH-1];
               cnt_in   = CNT_W'(STEPS - 1);
               state_in = b2da_pkg::FRONT_CONVERT;
            end
         end
         b2da_pkg::FRONT_CONVERT: begin
            bin_in = bin_step;
            bcd_in = bcd_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = b2da_pkg::FRONT_PUSH;
            end
         end
         b2da_pkg::FRONT_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = b2da_pkg::FRONT_IDLE;
            end
         end
         default: begin
            state_in = b2da_pkg::FRONT_IDLE;
         end
      endcase
   end

   // A request taken while idle keeps the front end busy on the next cycle.
   `ASSERT_CLK(a_front_busy_after_start, (start && !busy) |=> busy, "front end idle after a request")

endmodule

>>> sv/b2da_fifo.sv
// Two-entry queue between the converting front end and the emitting back end.
`include "assert_macros.svh"

module b2da_fifo #(
   parameter int WIDTH = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [1:0][WIDTH-1:0] mem_ff;
   logic                  wr_ptr_ff;
   logic                  rd_ptr_ff;
   logic [1:0]            count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_fifo_no_overflow, push && full, "request pushed into a full queue")
   `ASSERT_NEVER(a_fifo_no_underflow, pop && empty, "request popped from an empty queue")

endmodule

>>> sv/b2da_back.sv
// Back end: emits the sign and the decimal digits of one queued request per pass.
`include "assert_macros.svh"

module b2da_back #(
   parameter int NUM_DIGITS = 19,
   parameter int DIGIT_W    = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           queue_empty,
   input  logic [NUM_DIGITS*4+DIGIT_W:0]  pop_entry,
   output logic                           pop,
   output logic                           rsp_valid,
   output logic [5:0]                     rsp_char_code,
   output logic                           rsp_last
);

   localparam int BCD_W   = NUM_DIGITS * 4;
   localparam int ENTRY_W = BCD_W + DIGIT_W + 1;

   b2da_pkg::back_state_type state_ff, state_in;

   logic [NUM_DIGITS-1:0][3:0] digits_ff, digits_in;
   logic [DIGIT_W-1:0]         idx_ff, idx_in;
   logic                       load;

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
      digits_ff <= digits_in;
      idx_ff    <= idx_in;
   end

   // Next state and outputs.
   always_comb begin
      state_in      = state_ff;
      digits_in     = digits_ff;
      idx_in        = idx_ff;
      load          = 1'b0;
      rsp_valid     = 1'b0;
      rsp_char_code = b2da_pkg::CODE_ZERO + {2'b00, digits_ff[idx_ff]};
      rsp_last      = 1'b0;
      case (state_ff)
         b2da_pkg::BACK_IDLE: begin
            load = !queue_empty;
            if (queue_empty) begin
               state_in = b2da_pkg::BACK_IDLE;
            end
         end
         b2da_pkg::BACK_SIGN: begin
            rsp_valid     = 1'b1;
            rsp_char_code = b2da_pkg::CODE_MINUS;
            state_in      = b2da_pkg::BACK_DIGIT;
         end
         b2da_pkg::BACK_DIGIT: begin
            rsp_valid = 1'b1;
            if (idx_ff == '0) begin
               rsp_last = 1'b1;
               load     = !queue_empty;
               state_in = b2da_pkg::BACK_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = b2da_pkg::BACK_IDLE;
         end
      endcase

      // Take the next converted request when one waits, from idle or straight after the last digit.
      if (load) begin
         digits_in = pop_entry[BCD_W-1:0];
         idx_in    = pop_entry[ENTRY_W-2 -: DIGIT_W];
         state_in  = pop_entry[ENTRY_W-1] ? b2da_pkg::BACK_SIGN : b2da_pkg::BACK_DIGIT;
      end
      pop = load;
   end

   // Every character is a minus sign or a decimal digit.
   `ASSERT_CLK(a_back_char_legal, rsp_valid |-> ((rsp_char_code == b2da_pkg::CODE_MINUS) || ((rsp_char_code >= b2da_pkg::CODE_ZERO) && (rsp_char_code <= b2da_pkg::CODE_ZERO + 6'd9))), "illegal character code")

   // The minus sign is never the last character and is always followed by a digit.
   `ASSERT_CLK(a_back_sign_then_digit, (rsp_valid && rsp_char_code == b2da_pkg::CODE_MINUS) |=> (rsp_valid && rsp_char_code != b2da_pkg::CODE_MINUS), "minus sign not followed by a digit")

endmodule

>>> sv/binary_to_decimal_ascii.sv
// Top level of the signed binary to decimal ASCII converter.
//
// One request carries a two's complement value in the low VALUE_WIDTH bits of
// req_value; it is taken when start is high and busy is low. The text comes out
// one character per cycle on rsp_char_code with rsp_valid high, most significant
// character first, a minus sign before negative values, and rsp_last on the final
// digit. The receiver cannot stall: every character is valid for exactly one cycle.
// Busy is high while the front end converts and pushes a request, and low only
// while it is idle. The shift-and-add-3 BCD unit takes four bits per cycle; when
// the queue is full the front end waits after converting. A two-entry queue lets
// it run ahead of the back end, which goes on to the next queued request straight
// after the last digit and passes through its idle state when the queue ran dry.
// A request at 64 bits gives up to 20 characters. With the back end idle, the
// first character follows once the request is converted, pushed into the queue
// and loaded by the back end.
module binary_to_decimal_ascii #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   output logic [5:0]  rsp_char_code,
   output logic        rsp_last
);

   // Decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1).
   localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int DIGIT_W    = $clog2(NUM_DIGITS);
   localparam int ENTRY_W    = NUM_DIGITS * 4 + DIGIT_W + 1;

   logic               push;
   logic [ENTRY_W-1:0] push_entry;
   logic               queue_full;
   logic               pop;
   logic [ENTRY_W-1:0] pop_entry;
   logic               queue_empty;

   // Conversion front end.
   b2da_front #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS),
      .DIGIT_W     (DIGIT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue of converted requests.
   b2da_fifo #(
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_entry),
      .empty     (queue_empty)
   );

   // Character emitting back end.
   b2da_back #(
      .NUM_DIGITS (NUM_DIGITS),
      .DIGIT_W    (DIGIT_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .pop_entry     (pop_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

>>> tb/b2da_text_checker.sv
// Checker that predicts the decimal text of each request and compares the characters.
`timescale 1ns / 100ps

module b2da_text_checker #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [63:0] req_value,
   input  logic        rsp_valid,
   input  logic [5:0]  rsp_char_code,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_count
);

   // One character of the expected text.
   typedef struct packed {
      logic [5:0] char_code;
      logic       last;
   } char_item_type;

   char_item_type expected_chars [$];
   int            mismatches;

   initial begin
      mismatches    = 0;
      fail_count    = 0;
      pending_count = 0;
   end

   // Queue the characters that the decimal text of one request should produce.
   function automatic void predict_text(logic [63:0] raw);
      logic [63:0]   width_mask;
      logic [63:0]   operand;
      logic [63:0]   magnitude;
      logic          negative;
      logic [3:0]    digits [0:19];
      int            num_digits;
      char_item_type item;

      width_mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
      operand    = raw & width_mask;
      negative   = operand[VALUE_WIDTH-1];
      // The magnitude is taken in unsigned arithmetic, so the most negative
      // value needs no special handling.
      magnitude  = negative ? ((~operand + 64'd1) & width_mask) : operand;

      // Digits come out least significant first; zero still gives one digit.
      num_digits = 0;
      while (num_digits == 0 || (magnitude != 0 && num_digits < 19)) begin
         digits[num_digits] = 4'(magnitude % 64'd10);
         magnitude          = magnitude / 64'd10;
         num_digits++;
      end

      if (negative) begin
         item.char_code = b2da_pkg::CODE_MINUS;
         item.last      = 1'b0;
         expected_chars.push_back(item);
      end
      for (int k = num_digits - 1; k >= 0; k--) begin
         item.char_code = b2da_pkg::CODE_ZERO + digits[k];
         item.last      = (k == 0);
         expected_chars.push_back(item);
      end
   endfunction

   // Compare each character against the oldest expectation, then take new requests.
   always @(posedge clock) begin
      char_item_type want;

      if (!reset) begin
         if (rsp_valid) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character: char_code %0d, last %0d",
                      rsp_char_code, rsp_last);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.char_code) begin
                  $error("char_code mismatch: expected %0d, actual %0d",
                         want.char_code, rsp_char_code);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d",
                         want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            predict_text(req_value);
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_chars.size();
   end

endmodule

>>> tb/binary_to_decimal_ascii_tb.sv
// Testbench top for the binary to decimal ASCII converter: stimulus and verdict.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_tb;

   localparam int VALUE_WIDTH = 64;
   localparam int ITEMS_PER_PHASE = 95;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_value;
   logic        rsp_valid;
   logic [5:0]  rsp_char_code;
   logic        rsp_last;
   int          fail_count;
   int          pending_count;

   binary_to_decimal_ascii #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_char_code(rsp_char_code),
      .rsp_last(rsp_last)
   );

   b2da_text_checker #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) char_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_char_code(rsp_char_code),
      .rsp_last(rsp_last),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   // Free-running 2 ns clock.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Safety net in case the block hangs.
   initial begin
      #1000000;
      $display("TEST FAILED");
      $finish;
   end

   // Random value with a spread of digit counts, signs and boundary cases.
   function automatic logic [63:0] random_value();
      logic [63:0] magnitude;
      logic [63:0] power;
      int          kind;
      int          bits;

      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: begin
            bits      = $urandom_range(1, 63);
            magnitude = {$urandom, $urandom} >> (64 - bits);
         end
         4, 5: begin
            return {$urandom, $urandom};
         end
         6: begin
            // Unsigned 32-bit value, zero-extended.
            return {32'd0, $urandom};
         end
         7: begin
            // Just below, at or just above a power of ten.
            power = 64'd1;
            repeat ($urandom_range(0, 18)) power = power * 64'd10;
            magnitude = power + 64'd1 - 64'($urandom_range(0, 2));
         end
         8: begin
            magnitude = 64'($urandom_range(0, 20));
         end
         default: begin
            case ($urandom_range(0, 3))
               0: return 64'h8000_0000_0000_0000;
               1: return 64'h7FFF_FFFF_FFFF_FFFF;
               2: return 64'd0;
               default: return '1;
            endcase
         end
      endcase
      return $urandom_range(0, 1) ? (~magnitude + 64'd1) : magnitude;
   endfunction

   // Present one request, after an optional gap, and hold it until it is taken.
   // Gaps can run past the front end's busy time so the block also sees idle input.
   task automatic send_request(input logic [63:0] value, input int idle_percent);
      if ($urandom_range(1, 100) <= idle_percent) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      req_value <= value;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   logic [63:0] directed_values [$];
   int          phase_idle [4];

   initial begin
      start     = 1'b0;
      req_value = '0;
      reset     = 1'b1;

      directed_values = '{
         64'd0, 64'd1, '1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100,
         64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
         64'h0000_0000_FFFF_FFFF, 64'h0000_0000_8000_0000,
         64'd999999999999999999, 64'd1000000000000000000, -64'sd1000000000000000000,
         64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd12345, -64'sd12345
      };
      // Sender gaps per phase: none, heavy, light, none.
      phase_idle = '{0, 80, 25, 0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed requests back to back.
      foreach (directed_values[i]) begin
         send_request(directed_values[i], 0);
      end

      // Random requests under different sender gap rates.
      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_request(random_value(), phase_idle[phase]);
         end
      end
      start <= 1'b0;

      // Drain the text still in flight, then allow for any stray characters.
      do @(posedge clock); while (pending_count != 0);
      repeat (40) @(posedge clock);

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> binary_to_decimal_ascii.f
+incdir+sv
sv/b2da_pkg.sv
sv/b2da_front.sv
sv/b2da_fifo.sv
sv/b2da_back.sv
sv/binary_to_decimal_ascii.sv
tb/b2da_text_checker.sv
tb/binary_to_decimal_ascii_tb.sv
